>>> src/dwt_pkg.sv
// dwt_pkg: shared types, codes and constants for the dictionary word transform
// used by dwt_core and dictionary_word_transform; no dependencies

package dwt_pkg;

   // transform kinds
   localparam logic [4:0] FUNC_IDENTITY       = 5'd0;
   localparam logic [4:0] FUNC_UPPER_FIRST    = 5'd1;
   localparam logic [4:0] FUNC_UPPER_ALL      = 5'd2;
   localparam logic [4:0] FUNC_OMIT_FIRST_END = 5'd11;
   localparam logic [4:0] FUNC_OMIT_LAST_END  = 5'd20;
   localparam logic [4:0] OMIT_FIRST_BIAS     = 5'd2;
   localparam logic [4:0] OMIT_LAST_BIAS      = 5'd11;

   // utf-8 style case folding
   localparam logic [7:0] LEAD_TWO_BYTE   = 8'd192;
   localparam logic [7:0] LEAD_THREE_BYTE = 8'd224;
   localparam logic [7:0] LOWER_A         = 8'd97;
   localparam logic [7:0] LOWER_Z         = 8'd122;
   localparam logic [7:0] CASE_FLIP       = 8'd32;
   localparam logic [7:0] THIRD_FLIP      = 8'd5;

   localparam logic [5:0] POS_MAX = 6'd63;
   localparam logic [6:0] LEN_MAX = 7'd127;

   // parameter defaults
   localparam int DEF_FERMENT_START_LIMIT = 34;
   localparam int DEF_OUTPUT_CAP          = 37;
   localparam int DEF_MAX_WORD_LEN        = 32;

   typedef enum logic [1:0] {
      PHASE_START = 2'd0,
      PHASE_XOR32 = 2'd1,
      PHASE_COPY  = 2'd2,
      PHASE_XOR5  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [5:0] pos;
      logic [6:0] olen;
      phase_type  phase;
      logic       first_done;
      logic       active;
      logic       halted;
   } word_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_keep;
      logic [6:0] out_len;
      logic       out_last;
   } result_type;

endpackage

>>> src/dwt_core.sv
// dwt_core: per-byte transform logic, from current word state and one item
// to the result and the next word state; depends on dwt_pkg

module dwt_core
   import dwt_pkg::*;
#(
   parameter int FERMENT_START_LIMIT = DEF_FERMENT_START_LIMIT,
   parameter int OUTPUT_CAP          = DEF_OUTPUT_CAP,
   parameter int MAX_WORD_LEN        = DEF_MAX_WORD_LEN
) (
   input  logic [4:0]     func,
   input  logic [7:0]     in_byte,
   input  logic [5:0]     word_len,
   input  logic [5:0]     start_len,
   input  logic           in_last,
   input  word_state_type state_cur,
   output result_type     result,
   output word_state_type state_nxt
);

   localparam logic [6:0] START_LIMIT = 7'(FERMENT_START_LIMIT);
   localparam logic [6:0] CAP         = 7'(OUTPUT_CAP);
   localparam logic [5:0] WORD_MAX    = 6'(MAX_WORD_LEN);

   word_state_type st;
   word_state_type nx;
   logic [5:0]     wl;
   logic [4:0]     omit_n;
   logic           keep;
   logic [7:0]     val;
   logic           start_refused;
   logic [7:0]     brew_val;
   phase_type      brew_phase;

   // fresh word takes its start length
   always_comb begin
      st = state_cur;
      if (!state_cur.active) begin
         st.pos        = '0;
         st.olen       = {1'b0, start_len};
         st.phase      = PHASE_START;
         st.first_done = 1'b0;
         st.halted     = 1'b0;
         st.active     = 1'b1;
      end
   end

   assign wl = (word_len > WORD_MAX) ? WORD_MAX : word_len;

   // uppercasing of one byte
   always_comb begin
      brew_val   = in_byte;
      brew_phase = PHASE_START;
      case (st.phase)
         PHASE_XOR32: brew_val = in_byte ^ CASE_FLIP;
         PHASE_COPY:  brew_phase = PHASE_XOR5;
         PHASE_XOR5:  brew_val = in_byte ^ THIRD_FLIP;
         default: begin
            if (in_byte < LEAD_TWO_BYTE) begin
               if (in_byte >= LOWER_A && in_byte <= LOWER_Z) begin
                  brew_val = in_byte ^ CASE_FLIP;
               end
            end else if (in_byte < LEAD_THREE_BYTE) begin
               brew_phase = PHASE_XOR32;
            end else begin
               brew_phase = PHASE_COPY;
            end
         end
      endcase
   end

   assign start_refused = (st.phase == PHASE_START) && (st.olen >= START_LIMIT);

   always_comb begin
      nx     = st;
      keep   = 1'b0;
      val    = in_byte;
      omit_n = 5'd0;
      if (st.pos < wl && !st.halted) begin
         if (func == FUNC_IDENTITY) begin
            keep = 1'b1;
         end else if (func == FUNC_UPPER_FIRST) begin
            if (st.first_done) begin
               keep = (st.olen < CAP);
            end else if (start_refused) begin
               nx.halted = 1'b1;
            end else begin
               keep     = 1'b1;
               val      = brew_val;
               nx.phase = brew_phase;
               if (brew_phase == PHASE_START) begin
                  nx.first_done = 1'b1;
               end
            end
         end else if (func == FUNC_UPPER_ALL) begin
            if (start_refused) begin
               nx.halted = 1'b1;
            end else begin
               keep     = 1'b1;
               val      = brew_val;
               nx.phase = brew_phase;
            end
         end else if (func <= FUNC_OMIT_FIRST_END) begin
            omit_n = func - OMIT_FIRST_BIAS;
            keep   = (st.pos >= {1'b0, omit_n});
         end else if (func <= FUNC_OMIT_LAST_END) begin
            omit_n = func - OMIT_LAST_BIAS;
            keep   = (wl >= {1'b0, omit_n}) && (st.pos < wl - {1'b0, omit_n});
         end
      end
      if (keep && st.olen < LEN_MAX) begin
         nx.olen = st.olen + 7'd1;
      end
      if (st.pos < POS_MAX) begin
         nx.pos = st.pos + 6'd1;
      end
   end

   always_comb begin
      result.out_byte = keep ? val : 8'd0;
      result.out_keep = keep;
      result.out_len  = nx.olen;
      result.out_last = in_last;
      state_nxt       = nx;
      if (in_last) begin
         state_nxt.active     = 1'b0;
         state_nxt.pos        = '0;
         state_nxt.phase      = PHASE_START;
         state_nxt.first_done = 1'b0;
         state_nxt.halted     = 1'b0;
      end
   end

endmodule

>>> src/dictionary_word_transform.sv
// dictionary_word_transform: top level, word state and result register
// around dwt_core; depends on dwt_pkg and dwt_core
//
// usage
//   req_ channel carries one byte of a dictionary word per item, with the
//   transform kind, word length, start length and a last-byte mark
//   rsp_ channel returns one item per request item: the transformed byte,
//   whether it is kept, the running output length and the last mark
//   rsp_ is registered: a request accepted at one edge shows after that edge;
//   one item per cycle unless rsp_ stalls, set by the single result register
//   req_ready is high while the result register is empty or being drained, so
//   a stalled receiver holds the result and stops new items after one
//   the word state (position, length, case phase) advances on each accepted
//   item; all but the length is cleared when a word's last byte is accepted
//   start length is sampled on the first byte of each word
//   reset (synchronous, active high) empties the result register and clears
//   the word state

module dictionary_word_transform
   import dwt_pkg::*;
#(
   parameter int FERMENT_START_LIMIT = DEF_FERMENT_START_LIMIT,
   parameter int OUTPUT_CAP          = DEF_OUTPUT_CAP,
   parameter int MAX_WORD_LEN        = DEF_MAX_WORD_LEN
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [4:0] req_func,
   input  logic [7:0] req_in_byte,
   input  logic [5:0] req_word_len,
   input  logic [5:0] req_start_len,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_keep,
   output logic [6:0] rsp_out_len,
   output logic       rsp_out_last
);

   word_state_type state_ff;
   word_state_type state_in;
   result_type     result_ff;
   result_type     result_in;
   logic           valid_ff;
   logic           valid_in;
   logic           req_fire;

   // accept whenever the result slot is empty or frees up this cycle
   assign req_ready = !valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   dwt_core #(
      .FERMENT_START_LIMIT(FERMENT_START_LIMIT),
      .OUTPUT_CAP         (OUTPUT_CAP),
      .MAX_WORD_LEN       (MAX_WORD_LEN)
   ) u_core (
      .func      (req_func),
      .in_byte   (req_in_byte),
      .word_len  (req_word_len),
      .start_len (req_start_len),
      .in_last   (req_in_last),
      .state_cur (state_ff),
      .result    (result_in),
      .state_nxt (state_in)
   );

   // result slot stays full until taken
   always_comb begin
      valid_in = valid_ff;
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // payload, loaded only on acceptance
   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = result_ff.out_byte;
   assign rsp_out_keep = result_ff.out_keep;
   assign rsp_out_len  = result_ff.out_len;
   assign rsp_out_last = result_ff.out_last;

`ifndef SYNTHESIS
   // a kept byte always leaves a nonzero output length
   a_keep_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_keep |-> rsp_out_len != 7'd0)
      else $error("kept byte with zero output length");

   // dropped bytes read as zero
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_keep |-> rsp_out_byte == 8'd0)
      else $error("dropped byte not zero");

   // a last byte closes the word
   a_last_close: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_in_last |=> !state_ff.active && state_ff.pos == 6'd0)
      else $error("word state not cleared after last byte");

   // the result of an accepted item carries its last mark
   a_last_copy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid && rsp_out_last == $past(req_in_last))
      else $error("last mark not carried to result");
`endif

endmodule
